FILE: src/assert_macros.svh
// Assertion macros shared by the checker files.
// No dependencies; each use expands to one labelled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define DLCM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define DLCM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: src/dlcm_pkg.sv
// Shared types, constants and helpers of the display-list CLUT pixel mapper.
// No dependencies; imported by the mapper core, the top level and the checker.
`timescale 1ns / 1ps

package dlcm_pkg;

  localparam int unsigned ChCount = 32;
  localparam int unsigned IdxW    = $clog2(ChCount);
  localparam int unsigned ChW     = 8;
  localparam int unsigned PixW    = 16;
  localparam int unsigned WordW   = 32;
  localparam int unsigned RgbW    = 3 * ChW;

  localparam logic [RgbW-1:0] BgReset = 24'h010101;

  typedef logic [ChW-1:0] lut_t [ChCount];

  // Control flags set by a control word.
  typedef struct packed {
    logic bypass;
    logic bg_en;
    logic rnd_fill;
    logic msb_rep;
  } dlcm_ctrl_t;

  typedef enum logic [1:0] {
    CMD_BG,
    CMD_CTRL,
    CMD_IGNORE,
    CMD_PALETTE
  } cmd_kind_e;

  // Palette write select, word bits 30..29.
  typedef enum logic [1:0] {
    SEL_ALL   = 2'd0,
    SEL_BLUE  = 2'd1,
    SEL_GREEN = 2'd2,
    SEL_RED   = 2'd3
  } pal_sel_e;

  localparam logic [7:0] BgTag   = 8'hE0;
  localparam logic [2:0] CtrlTag = 3'b110;

  function automatic cmd_kind_e cmd_kind(input logic [WordW-1:0] w);
    cmd_kind_e k;
    if (w[31:24] == BgTag) begin
      k = CMD_BG;
    end else if (w[31:29] == CtrlTag) begin
      k = CMD_CTRL;
    end else if (w[31]) begin
      k = CMD_IGNORE;
    end else begin
      k = CMD_PALETTE;
    end
    return k;
  endfunction

  // Reset ramp: entry i = round(255 * i / 31).
  localparam lut_t RampLut = '{
    8'd0,   8'd8,   8'd16,  8'd25,  8'd33,  8'd41,  8'd49,  8'd58,
    8'd66,  8'd74,  8'd82,  8'd90,  8'd99,  8'd107, 8'd115, 8'd123,
    8'd132, 8'd140, 8'd148, 8'd156, 8'd165, 8'd173, 8'd181, 8'd189,
    8'd197, 8'd206, 8'd214, 8'd222, 8'd230, 8'd239, 8'd247, 8'd255
  };

endpackage

FILE: src/dlcm_pixel_map.sv
// Pixel mapping core: background, bypass widening or table lookup result.
// Depends on dlcm_pkg; table entries are read by the caller.
`timescale 1ns / 1ps

module dlcm_pixel_map (
  input  logic [dlcm_pkg::PixW-1:0] pixel_i,
  input  dlcm_pkg::dlcm_ctrl_t      ctrl_i,
  input  logic [dlcm_pkg::RgbW-1:0] bg_i,
  input  logic [dlcm_pkg::ChW-1:0]  red_lut_i,
  input  logic [dlcm_pkg::ChW-1:0]  green_lut_i,
  input  logic [dlcm_pkg::ChW-1:0]  blue_lut_i,
  output logic [dlcm_pkg::RgbW-1:0] rgb_o       // red 7:0, green 15:8, blue 23:16
);
  import dlcm_pkg::*;

  function automatic logic [ChW-1:0] widen(input logic [IdxW-1:0] v, input dlcm_ctrl_t c);
    logic [2:0] low;
    if (c.rnd_fill) begin
      low = 3'd3;
    end else if (c.msb_rep) begin
      low = v[IdxW-1 -: 3];
    end else begin
      low = 3'd0;
    end
    return {v, low};
  endfunction

  logic bg_hit;
  logic byp_hit;

  assign bg_hit  = ctrl_i.bg_en && (pixel_i[14:0] == 15'd0);
  assign byp_hit = ctrl_i.bypass && pixel_i[15];

  always_comb begin
    if (bg_hit) begin
      rgb_o = {bg_i[7:0], bg_i[15:8], bg_i[23:16]};
    end else if (byp_hit) begin
      rgb_o = {widen(pixel_i[4:0], ctrl_i), widen(pixel_i[9:5], ctrl_i),
               widen(pixel_i[14:10], ctrl_i)};
    end else begin
      rgb_o = {blue_lut_i, green_lut_i, red_lut_i};
    end
  end

endmodule

FILE: src/display_list_clut_pixel_mapper.sv
// Top level of the display-list CLUT pixel mapper: input stage, tables, result stage.
// Depends on dlcm_pkg and dlcm_pixel_map.
//
//  channel  | dir | tdata                   | tuser
//  s_axis   | in  | [31:0] data_word        | opcode (0 command, 1 pixel)
//  m_axis   | out | [23:0] red, green, blue | -
//
// One word per clock while the result is not stalled. A word is registered on entry;
// a command updates the tables or flags as it leaves that register, a pixel is mapped
// in the same cycle through one 32-entry lookup per channel into the result register.
// Pixel tvalid rises once the word has passed the input and result registers. Commands give no output.
// Reset (async, active low) reloads the ramp tables, background 0x010101, flags off.
// A stalled result holds; words are still taken until a pixel waits in the input register.
`timescale 1ns / 1ps

module display_list_clut_pixel_mapper (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [dlcm_pkg::WordW-1:0]   s_axis_tdata_i,   // data_word [31:0]
  input  logic                         s_axis_tuser_i,   // opcode [0]
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [dlcm_pkg::RgbW-1:0]    m_axis_tdata_o    // red 7:0, green 15:8, blue 23:16
);
  import dlcm_pkg::*;

  // Input stage
  logic              s1_valid_q;
  logic              s1_pixel_q;
  logic [WordW-1:0]  s1_word_q;

  // Result stage
  logic              out_valid_q;
  logic [RgbW-1:0]   out_data_q;

  // Tables and display state
  lut_t              red_q;
  lut_t              green_q;
  lut_t              blue_q;
  logic [RgbW-1:0]   bg_q;
  dlcm_ctrl_t        ctrl_q;

  logic              out_free;
  logic              s1_adv;
  logic              pix_fire;
  logic              cmd_fire;
  cmd_kind_e         kind;
  pal_sel_e          sel;
  logic [IdxW-1:0]   wr_idx;
  logic [RgbW-1:0]   rgb;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign pix_fire        = s1_valid_q && s1_pixel_q && out_free;
  assign cmd_fire        = s1_valid_q && !s1_pixel_q;
  assign s1_adv          = pix_fire || cmd_fire;
  assign s_axis_tready_o = !s1_valid_q || s1_adv;

  assign kind   = cmd_kind(s1_word_q);
  assign sel    = pal_sel_e'(s1_word_q[30:29]);
  assign wr_idx = s1_word_q[24 +: IdxW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      s1_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      s1_pixel_q <= s_axis_tuser_i;
      s1_word_q  <= s_axis_tdata_i;
    end
  end

  // Command decode; writes land before the next word is mapped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_q   <= RampLut;
      green_q <= RampLut;
      blue_q  <= RampLut;
      bg_q    <= BgReset;
      ctrl_q  <= '0;
    end else if (cmd_fire) begin
      case (kind)
        CMD_BG: begin
          bg_q <= s1_word_q[RgbW-1:0];
        end
        CMD_CTRL: begin
          ctrl_q.bypass   <= s1_word_q[25];
          ctrl_q.bg_en    <= s1_word_q[22];
          ctrl_q.rnd_fill <= s1_word_q[12];
          ctrl_q.msb_rep  <= s1_word_q[11];
        end
        CMD_PALETTE: begin
          case (sel)
            SEL_ALL: begin
              red_q[wr_idx]   <= s1_word_q[23:16];
              green_q[wr_idx] <= s1_word_q[15:8];
              blue_q[wr_idx]  <= s1_word_q[7:0];
            end
            SEL_BLUE:  blue_q[wr_idx]  <= s1_word_q[7:0];
            SEL_GREEN: green_q[wr_idx] <= s1_word_q[15:8];
            SEL_RED:   red_q[wr_idx]   <= s1_word_q[23:16];
            default:   ;
          endcase
        end
        default: ;  // ignored words
      endcase
    end
  end

  dlcm_pixel_map u_map (
    .pixel_i     (s1_word_q[PixW-1:0]),
    .ctrl_i      (ctrl_q),
    .bg_i        (bg_q),
    .red_lut_i   (red_q[s1_word_q[14:10]]),
    .green_lut_i (green_q[s1_word_q[9:5]]),
    .blue_lut_i  (blue_q[s1_word_q[4:0]]),
    .rgb_o       (rgb)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= pix_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_fire) begin
      out_data_q <= rgb;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

FILE: src/dlcm_checker.sv
// Port-level checks for the display-list CLUT pixel mapper, bound to the top level.
// Depends on dlcm_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dlcm_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid_i,
  input logic                       s_axis_tready_o,
  input logic [dlcm_pkg::WordW-1:0] s_axis_tdata_i,
  input logic                       s_axis_tuser_i,
  input logic                       m_axis_tvalid_o,
  input logic                       m_axis_tready_i,
  input logic [dlcm_pkg::RgbW-1:0]  m_axis_tdata_o
);
  import dlcm_pkg::*;

  logic pix_in;
  assign pix_in = s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i;

  // no result word while reset is held
  `DLCM_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |-> !m_axis_tvalid_o, "output valid in reset")

  // a stalled result word keeps its data
  `DLCM_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o), "stalled result changed")

  // a rising output valid must trace back to an accepted pixel
  `DLCM_ASSERT(a_out_origin, clk_i, rst_ni, $rose(m_axis_tvalid_o) |-> $past(pix_in, 2), "result without pixel")

  // with nothing offered and nothing pending, the input side must be open
  `DLCM_ASSERT(a_drain_ready, clk_i, rst_ni, !$past(s_axis_tvalid_i) && !$past(m_axis_tvalid_o) |-> s_axis_tready_o, "input blocked when empty")

endmodule

bind display_list_clut_pixel_mapper dlcm_checker u_dlcm_checker (.*);
